/* rtl/tpe_pkg.sv */
`timescale 1ns / 1ps

package tpe_pkg;

    // result phase codes
    typedef enum logic [2:0] {
        PH_ACCEL  = 3'd0,
        PH_CRUISE = 3'd1,
        PH_DECEL  = 3'd2,
        PH_DONE   = 3'd3,
        PH_ERROR  = 3'd4
    } phase_t;

    // configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL    = 1'b1;

endpackage

/* rtl/tpe_if.sv */
`timescale 1ns / 1ps

// input beat: move distance and elapsed time
interface tpe_in_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] move_distance;
    logic        [W-1:0] elapsed_time;

    modport source (output valid, output move_distance, output elapsed_time, input ready);
    modport sink   (input valid, input move_distance, input elapsed_time, output ready);
endinterface

// result beat: position, speed and phase
interface tpe_out_if #(parameter int W = 32);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] position;
    logic        [W-1:0] speed;
    logic        [2:0]   phase;

    modport source (output valid, output position, output speed, output phase, input ready);
    modport sink   (input valid, input position, input speed, input phase, output ready);
endinterface

/* rtl/tpe_div_pipe.sv */
`timescale 1ns / 1ps

// two-lane restoring divider, one quotient bit per stage
module tpe_div_pipe #(
    parameter int W    = 32,
    parameter int NW   = 64,
    parameter int SB_W = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [NW-1:0]   num1,
    input  logic [W-1:0]    den1,
    input  logic [NW-1:0]   num2,
    input  logic [W-1:0]    den2,
    input  logic [SB_W-1:0] sb_in,
    output logic            out_valid,
    output logic [NW-1:0]   quo1,
    output logic [NW-1:0]   quo2,
    output logic [SB_W-1:0] sb_out
);

    logic            vld_reg  [1:NW];
    logic [W-1:0]    rem1_reg [1:NW];
    logic [W-1:0]    rem2_reg [1:NW];
    logic [NW-1:0]   nq1_reg  [1:NW];
    logic [NW-1:0]   nq2_reg  [1:NW];
    logic [W-1:0]    d1_reg   [1:NW];
    logic [W-1:0]    d2_reg   [1:NW];
    logic [SB_W-1:0] sb_reg   [1:NW];

    logic            vld_src  [0:NW-1];
    logic [W-1:0]    rem1_src [0:NW-1];
    logic [W-1:0]    rem2_src [0:NW-1];
    logic [NW-1:0]   nq1_src  [0:NW-1];
    logic [NW-1:0]   nq2_src  [0:NW-1];
    logic [W-1:0]    d1_src   [0:NW-1];
    logic [W-1:0]    d2_src   [0:NW-1];
    logic [SB_W-1:0] sb_src   [0:NW-1];

    genvar i;
    generate
        for (i = 0; i < NW; i++)
        begin : g_stage
            logic [W:0] sh1;
            logic [W:0] sh2;
            logic       ge1;
            logic       ge2;

            // stage inputs
            if (i == 0)
            begin : g_first
                assign vld_src[i]  = in_valid;
                assign rem1_src[i] = '0;
                assign rem2_src[i] = '0;
                assign nq1_src[i]  = num1;
                assign nq2_src[i]  = num2;
                assign d1_src[i]   = den1;
                assign d2_src[i]   = den2;
                assign sb_src[i]   = sb_in;
            end
            else
            begin : g_next
                assign vld_src[i]  = vld_reg[i];
                assign rem1_src[i] = rem1_reg[i];
                assign rem2_src[i] = rem2_reg[i];
                assign nq1_src[i]  = nq1_reg[i];
                assign nq2_src[i]  = nq2_reg[i];
                assign d1_src[i]   = d1_reg[i];
                assign d2_src[i]   = d2_reg[i];
                assign sb_src[i]   = sb_reg[i];
            end

            // trial subtract
            assign sh1 = {rem1_src[i], nq1_src[i][NW-1]};
            assign sh2 = {rem2_src[i], nq2_src[i][NW-1]};
            assign ge1 = sh1 >= {1'b0, d1_src[i]};
            assign ge2 = sh2 >= {1'b0, d2_src[i]};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i+1] <= vld_src[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem1_reg[i+1] <= ge1 ? W'(sh1 - {1'b0, d1_src[i]}) : sh1[W-1:0];
                    rem2_reg[i+1] <= ge2 ? W'(sh2 - {1'b0, d2_src[i]}) : sh2[W-1:0];
                    nq1_reg[i+1]  <= {nq1_src[i][NW-2:0], ge1};
                    nq2_reg[i+1]  <= {nq2_src[i][NW-2:0], ge2};
                    d1_reg[i+1]   <= d1_src[i];
                    d2_reg[i+1]   <= d2_src[i];
                    sb_reg[i+1]   <= sb_src[i];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NW];
    assign quo1      = nq1_reg[NW];
    assign quo2      = nq2_reg[NW];
    assign sb_out    = sb_reg[NW];

endmodule

/* rtl/tpe_sqrt_pipe.sv */
`timescale 1ns / 1ps

// digit-by-digit integer square root, one root bit per stage
module tpe_sqrt_pipe #(
    parameter int NW   = 64,
    parameter int SB_W = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [NW-1:0]        radicand,
    input  logic [SB_W-1:0]      sb_in,
    output logic                 out_valid,
    output logic [(NW+1)/2-1:0]  root,
    output logic [SB_W-1:0]      sb_out
);

    localparam int NR = (NW + 1) / 2;
    localparam int NX = 2 * NR;

    logic            vld_reg  [1:NR];
    logic [NR:0]     rem_reg  [1:NR];
    logic [NR-1:0]   rt_reg   [1:NR];
    logic [NX-1:0]   x_reg    [1:NR];
    logic [SB_W-1:0] sb_reg   [1:NR];

    logic            vld_src  [0:NR-1];
    logic [NR:0]     rem_src  [0:NR-1];
    logic [NR-1:0]   rt_src   [0:NR-1];
    logic [NX-1:0]   x_src    [0:NR-1];
    logic [SB_W-1:0] sb_src   [0:NR-1];

    genvar j;
    generate
        for (j = 0; j < NR; j++)
        begin : g_stage
            logic [NR+2:0] sh;
            logic [NR+2:0] trial;
            logic          ge;

            if (j == 0)
            begin : g_first
                assign vld_src[j] = in_valid;
                assign rem_src[j] = '0;
                assign rt_src[j]  = '0;
                assign x_src[j]   = NX'(radicand);
                assign sb_src[j]  = sb_in;
            end
            else
            begin : g_next
                assign vld_src[j] = vld_reg[j];
                assign rem_src[j] = rem_reg[j];
                assign rt_src[j]  = rt_reg[j];
                assign x_src[j]   = x_reg[j];
                assign sb_src[j]  = sb_reg[j];
            end

            // bring down two bits and try root*4+1
            assign sh    = {rem_src[j], x_src[j][NX-1:NX-2]};
            assign trial = {1'b0, rt_src[j], 2'b01};
            assign ge    = sh >= trial;

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[j+1] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[j+1] <= vld_src[j];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[j+1] <= ge ? (NR+1)'(sh - trial) : sh[NR:0];
                    rt_reg[j+1]  <= {rt_src[j][NR-2:0], ge};
                    x_reg[j+1]   <= {x_src[j][NX-3:0], 2'b00};
                    sb_reg[j+1]  <= sb_src[j];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NR];
    assign root      = rt_reg[NR];
    assign sb_out    = sb_reg[NR];

endmodule

/* rtl/tpe_eval_pipe.sv */
`timescale 1ns / 1ps

// profile times, phase select, multiplies and output register
module tpe_eval_pipe #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int NR = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [W-1:0]        vel,
    input  logic [W-1:0]        acc,
    input  logic [NR-1:0]       root,
    input  logic [W-1:0]        q1_sat,
    input  logic [W-1:0]        q2_sat,
    input  logic [W-1:0]        dist_mag,
    input  logic                neg,
    input  logic [W-1:0]        tim,
    input  logic                cruise,
    input  logic                err,
    output logic                out_valid,
    output logic signed [W-1:0] position,
    output logic [W-1:0]        speed,
    output logic [2:0]          phase
);

    localparam int MXW = (NR > W) ? NR : W;
    localparam logic [W-1:0] UMAX = '1;
    localparam logic [W-1:0] PMAX = UMAX >> 1;

    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // stage 0: acceleration and total time
    logic [MXW-1:0] root_ext;
    logic [W-1:0]   ta_tri;
    logic [W-1:0]   ta_next;
    logic [W-1:0]   tt_next;
    logic [W:0]     sum_cr;
    logic [W:0]     sum_tri;
    logic [W-1:0]   ta0_reg, tt0_reg, d0_reg, t0_reg;
    logic           n0_reg, e0_reg;

    assign root_ext = MXW'(root);
    assign ta_tri   = (root_ext > MXW'(UMAX)) ? UMAX : W'(root_ext);
    assign sum_cr   = {1'b0, q2_sat} + {1'b0, q1_sat};
    assign sum_tri  = {1'b0, ta_tri} + {1'b0, ta_tri};

    always_comb
    begin
        if (cruise)
        begin
            ta_next = q1_sat;
            tt_next = sum_cr[W] ? UMAX : sum_cr[W-1:0];
        end
        else
        begin
            ta_next = ta_tri;
            tt_next = sum_tri[W] ? UMAX : sum_tri[W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta0_reg <= ta_next;
            tt0_reg <= tt_next;
            d0_reg  <= dist_mag;
            t0_reg  <= tim;
            n0_reg  <= neg;
            e0_reg  <= err;
        end
    end

    // stage 1: phase and multiply operands
    tpe_pkg::phase_t ph_next;
    logic [W-1:0]    x_next;
    tpe_pkg::phase_t ph1_reg;
    logic [W-1:0]    x1_reg, cx1_reg, d1_reg;
    logic            n1_reg;

    always_comb
    begin
        x_next = t0_reg;
        if (e0_reg)
        begin
            ph_next = tpe_pkg::PH_ERROR;
        end
        else if (t0_reg > tt0_reg)
        begin
            ph_next = tpe_pkg::PH_DONE;
        end
        else if (t0_reg <= ta0_reg)
        begin
            ph_next = tpe_pkg::PH_ACCEL;
        end
        else if (t0_reg < tt0_reg - ta0_reg)
        begin
            ph_next = tpe_pkg::PH_CRUISE;
            x_next  = ta0_reg;
        end
        else
        begin
            ph_next = tpe_pkg::PH_DECEL;
            x_next  = tt0_reg - t0_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ph1_reg <= ph_next;
            x1_reg  <= x_next;
            cx1_reg <= t0_reg - ta0_reg;
            d1_reg  <= d0_reg;
            n1_reg  <= n0_reg;
        end
    end

    // stage 2: a*x and (t-ta)*v
    tpe_pkg::phase_t ph2_reg;
    logic [2*W-1:0]  p1_reg, p3_reg;
    logic [W-1:0]    x2_reg, d2_reg;
    logic            n2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg  <= (2*W)'(acc) * (2*W)'(x1_reg);
            p3_reg  <= (2*W)'(cx1_reg) * (2*W)'(vel);
            ph2_reg <= ph1_reg;
            x2_reg  <= x1_reg;
            d2_reg  <= d1_reg;
            n2_reg  <= n1_reg;
        end
    end

    // stage 3: scale and saturate
    tpe_pkg::phase_t ph3_reg;
    logic [W-1:0]    s3_reg, c3_reg, x3_reg, d3_reg;
    logic            n3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg  <= (|p1_reg[2*W-1:W+F]) ? UMAX : p1_reg[W+F-1:F];
            c3_reg  <= (|p3_reg[2*W-1:W+F]) ? UMAX : p3_reg[W+F-1:F];
            ph3_reg <= ph2_reg;
            x3_reg  <= x2_reg;
            d3_reg  <= d2_reg;
            n3_reg  <= n2_reg;
        end
    end

    // stage 4: half-square product
    tpe_pkg::phase_t ph4_reg;
    logic [2*W-1:0]  p2_reg;
    logic [W-1:0]    s4_reg, c4_reg, d4_reg;
    logic            n4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_reg  <= (2*W)'(s3_reg) * (2*W)'(x3_reg);
            s4_reg  <= s3_reg;
            c4_reg  <= c3_reg;
            ph4_reg <= ph3_reg;
            d4_reg  <= d3_reg;
            n4_reg  <= n3_reg;
        end
    end

    // stage 5: magnitude, clamp and sign
    logic [W-1:0]    h;
    logic [W:0]      crsum;
    logic [W-1:0]    mag;
    logic [W-1:0]    lim;
    logic [W-1:0]    mag_c;
    logic [W-1:0]    spd_next;
    logic [W-1:0]    pos_next;
    logic signed [W-1:0] pos_reg;
    logic [W-1:0]    spd_reg;
    tpe_pkg::phase_t ph5_reg;

    assign h     = (|p2_reg[2*W-1:W+F+1]) ? UMAX : p2_reg[W+F:F+1];
    assign crsum = {1'b0, h} + {1'b0, c4_reg};
    assign lim   = n4_reg ? PMAX + W'(1) : PMAX;

    always_comb
    begin
        case (ph4_reg)
            tpe_pkg::PH_ACCEL:
            begin
                mag      = h;
                spd_next = s4_reg;
            end
            tpe_pkg::PH_CRUISE:
            begin
                mag      = crsum[W] ? UMAX : crsum[W-1:0];
                spd_next = vel;
            end
            tpe_pkg::PH_DECEL:
            begin
                mag      = (h > d4_reg) ? '0 : d4_reg - h;
                spd_next = s4_reg;
            end
            tpe_pkg::PH_DONE:
            begin
                mag      = d4_reg;
                spd_next = '0;
            end
            default:
            begin
                mag      = '0;
                spd_next = '0;
            end
        endcase
        mag_c    = (mag > lim) ? lim : mag;
        pos_next = n4_reg ? W'(0) - mag_c : mag_c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pos_reg <= pos_next;
            spd_reg <= spd_next;
            ph5_reg <= ph4_reg;
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    assign out_valid = v5_reg;
    assign position  = pos_reg;
    assign speed     = spd_reg;
    assign phase     = ph5_reg;

endmodule

/* rtl/trapezoid_profile_eval_unit.sv */
`timescale 1ns / 1ps

// Trapezoidal move profile evaluator.
// Channel sample carries a signed move distance and an elapsed time; channel
// result returns the signed position, the speed magnitude and the phase
// (accelerate, cruise, decelerate, done, error), all but phase fixed point with
// FRACTION_BITS fraction bits. Limits are written over cfg_we/cfg_index/
// cfg_data: index 0 velocity limit, index 1 acceleration limit.
// One beat is taken per cycle while the result is not stalled, and each beat
// gives one result beat. The pipeline is the front stage, the divider (one
// quotient bit per stage, N stages with N = VALUE_WIDTH + 2*FRACTION_BITS),
// the square root (one root bit per stage) and the evaluation stages.
// Reset clears all valid bits and sets both limits to 1.0.
// While the result beat is held by the receiver the whole pipeline freezes
// and sample.ready drops; nothing is lost or repeated.
module trapezoid_profile_eval_unit #(
    parameter int VALUE_WIDTH   = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tpe_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [VALUE_WIDTH-1:0]          cfg_data,
    tpe_in_if.sink                          sample,
    tpe_out_if.source                       result
);

    localparam int W    = VALUE_WIDTH;
    localparam int F    = FRACTION_BITS;
    localparam int NW   = W + 2 * F;
    localparam int NR   = (NW + 1) / 2;
    localparam int SB1  = 2 * W + 3;
    localparam int SB2  = 4 * W + 3;
    localparam logic [W-1:0] ONE  = {{(W-1){1'b0}}, 1'b1} << F;
    localparam logic [W-1:0] UMAX = '1;

    logic en;
    logic [W-1:0] vel_reg, acc_reg;

    // limit registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vel_reg <= ONE;
            acc_reg <= ONE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tpe_pkg::REG_VELOCITY: vel_reg <= cfg_data;
                tpe_pkg::REG_ACCEL:    acc_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    // pipeline advances unless a result beat is stuck
    assign en           = !result.valid || result.ready;
    assign sample.ready = en;

    // front stage: magnitude and cruise test products
    logic [W-1:0]   raw, d_in;
    logic           fv_reg, fn_reg;
    logic [W-1:0]   fd_reg, ft_reg;
    logic [2*W-1:0] pad_reg, pvv_reg;

    assign raw  = sample.move_distance;
    assign d_in = raw[W-1] ? W'(0) - raw : raw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else if (en)
        begin
            fv_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fn_reg  <= raw[W-1];
            fd_reg  <= d_in;
            ft_reg  <= sample.elapsed_time;
            pad_reg <= (2*W)'(acc_reg) * (2*W)'(d_in);
            pvv_reg <= (2*W)'(vel_reg) * (2*W)'(vel_reg);
        end
    end

    // divider operands
    logic          cruise, err;
    logic [NW-1:0] num1, num2;

    assign cruise = pad_reg > pvv_reg;
    assign err    = (vel_reg == '0) || (acc_reg == '0);
    assign num1   = cruise ? (NW'(vel_reg) << F) : (NW'(fd_reg) << (2 * F));
    assign num2   = NW'(fd_reg) << F;

    logic           dv_valid;
    logic [NW-1:0]  quo1, quo2;
    logic [SB1-1:0] sb1_out;
    logic [W-1:0]   q1s, q2s;

    tpe_div_pipe #(
        .W    (W),
        .NW   (NW),
        .SB_W (SB1)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fv_reg),
        .num1      (num1),
        .den1      (acc_reg),
        .num2      (num2),
        .den2      (vel_reg),
        .sb_in     ({fd_reg, fn_reg, ft_reg, cruise, err}),
        .out_valid (dv_valid),
        .quo1      (quo1),
        .quo2      (quo2),
        .sb_out    (sb1_out)
    );

    // saturate the cruise quotients before the root stages
    assign q1s = (quo1 > NW'(UMAX)) ? UMAX : quo1[W-1:0];
    assign q2s = (quo2 > NW'(UMAX)) ? UMAX : quo2[W-1:0];

    logic           sq_valid;
    logic [NR-1:0]  root;
    logic [SB2-1:0] sb2_out;

    tpe_sqrt_pipe #(
        .NW   (NW),
        .SB_W (SB2)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dv_valid),
        .radicand  (quo1),
        .sb_in     ({sb1_out, q1s, q2s}),
        .out_valid (sq_valid),
        .root      (root),
        .sb_out    (sb2_out)
    );

    logic                ev_valid;
    logic signed [W-1:0] ev_pos;
    logic [W-1:0]        ev_speed;
    logic [2:0]          ev_phase;

    tpe_eval_pipe #(
        .W  (W),
        .F  (F),
        .NR (NR)
    ) u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .vel       (vel_reg),
        .acc       (acc_reg),
        .root      (root),
        .q1_sat    (sb2_out[2*W-1:W]),
        .q2_sat    (sb2_out[W-1:0]),
        .dist_mag  (sb2_out[4*W+2:3*W+3]),
        .neg       (sb2_out[3*W+2]),
        .tim       (sb2_out[3*W+1:2*W+2]),
        .cruise    (sb2_out[2*W+1]),
        .err       (sb2_out[2*W]),
        .out_valid (ev_valid),
        .position  (ev_pos),
        .speed     (ev_speed),
        .phase     (ev_phase)
    );

    assign result.valid    = ev_valid;
    assign result.position = ev_pos;
    assign result.speed    = ev_speed;
    assign result.phase    = ev_phase;

endmodule

/* rtl/tpe_checker.sv */
`timescale 1ns / 1ps

// port-level checks on the profile evaluator
module tpe_checker #(
    parameter int W = 32
) (
    input logic         clk,
    input logic         rst_n,
    input logic         in_ready,
    input logic         out_valid,
    input logic         out_ready,
    input logic [W-1:0] position,
    input logic [W-1:0] speed,
    input logic [2:0]   phase
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(position) && $stable(speed)
            && $stable(phase))
        else $error("result beat changed under stall");

    // input is taken whenever no result is pending
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // error results carry zeros
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase == tpe_pkg::PH_ERROR |-> position == '0 && speed == '0)
        else $error("error result not zero");

    // finished moves stand still
    a_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase == tpe_pkg::PH_DONE |-> speed == '0)
        else $error("done result with nonzero speed");

endmodule

bind trapezoid_profile_eval_unit tpe_checker #(
    .W (VALUE_WIDTH)
) u_tpe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (sample.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .position  (result.position),
    .speed     (result.speed),
    .phase     (result.phase)
);

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int W = 32;
    localparam int F = 16;
    localparam int LATENCY = 7 + (W + 2 * F) + (W + 2 * F + 1) / 2;
    localparam logic [63:0] UMAX = 64'hFFFF_FFFF;
    localparam logic [63:0] PMAX = 64'h7FFF_FFFF;

    typedef struct packed {
        logic [W-1:0]    position;
        logic [W-1:0]    speed;
        tpe_pkg::phase_t phase;
    } profile_point_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [tpe_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [W-1:0] cfg_data;

    tpe_in_if  #(.W(W)) sample_if ();
    tpe_out_if #(.W(W)) result_if ();

    trapezoid_profile_eval_unit #(.VALUE_WIDTH(W), .FRACTION_BITS(F)) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_if.sink),
        .result    (result_if.source)
    );

    // predictor copy of the limits
    logic [W-1:0] vel_lim;
    logic [W-1:0] acc_lim;

    profile_point_t expected_points[$];
    int mismatches;
    int points_checked;
    int moves_sent;
    bit idle_on;
    int phase_seen[5];

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #80_000_000;
        $display("timeout");
        $display("FAIL trapezoid_profile_eval_unit");
        $finish;
    end

    // saturating helpers on wide products
    function automatic logic [63:0] sat_u(logic [127:0] x);
        return (x > 128'(UMAX)) ? UMAX : x[63:0];
    endfunction

    function automatic logic [63:0] scale_mul(logic [63:0] x, logic [63:0] y);
        logic [127:0] p;
        p = (128'(x) * 128'(y)) >> F;
        return sat_u(p);
    endfunction

    function automatic logic [63:0] half_square(logic [63:0] a, logic [63:0] t);
        logic [127:0] p;
        p = (128'(scale_mul(a, t)) * 128'(t)) >> (F + 1);
        return sat_u(p);
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] x, logic [63:0] y);
        return (x + y > UMAX) ? UMAX : x + y;
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] x);
        logic [63:0] res;
        logic [63:0] c;
        res = 0;
        for (int b = 63; b >= 0; b--)
        begin
            c = res | (64'd1 << b);
            if (128'(c) * 128'(c) <= x)
                res = c;
        end
        return res;
    endfunction

    function automatic profile_point_t eval_profile(logic [W-1:0] move_dist, logic [W-1:0] tm);
        profile_point_t pt;
        logic neg;
        logic [W-1:0] neg_dist;
        logic [63:0] d, v, a, t, ta, tt, mag, spd, h, lim;
        tpe_pkg::phase_t ph;
        neg = move_dist[W-1];
        neg_dist = ~move_dist + 1'b1;
        d = neg ? 64'(neg_dist) : 64'(move_dist);
        v = 64'(vel_lim);
        a = 64'(acc_lim);
        t = 64'(tm);
        if (v == 0 || a == 0)
        begin
            pt.position = '0;
            pt.speed = '0;
            pt.phase = tpe_pkg::PH_ERROR;
            return pt;
        end
        if (128'(a) * 128'(d) > 128'(v) * 128'(v))
        begin
            ta = sat_u((128'(v) << F) / 128'(a));
            tt = add_sat(sat_u((128'(d) << F) / 128'(v)), ta);
        end
        else
        begin
            ta = sat_u(128'(isqrt((128'(d) << (2 * F)) / 128'(a))));
            tt = add_sat(ta, ta);
        end
        if (t > tt)
        begin
            ph = tpe_pkg::PH_DONE; mag = d; spd = 0;
        end
        else if (t <= ta)
        begin
            ph = tpe_pkg::PH_ACCEL; spd = scale_mul(a, t); mag = half_square(a, t);
        end
        else if (t < tt - ta)
        begin
            ph = tpe_pkg::PH_CRUISE; spd = v;
            mag = add_sat(half_square(a, ta), scale_mul(t - ta, v));
        end
        else
        begin
            ph = tpe_pkg::PH_DECEL;
            spd = scale_mul(a, tt - t);
            h = half_square(a, tt - t);
            mag = (h > d) ? 0 : d - h;
        end
        lim = neg ? PMAX + 1 : PMAX;
        if (mag > lim)
            mag = lim;
        pt.position = neg ? W'(64'd0 - mag) : W'(mag);
        pt.speed = W'(spd);
        pt.phase = ph;
        return pt;
    endfunction

    // one move evaluation per beat, prediction on acceptance
    task automatic send_move(logic [W-1:0] move_dist, logic [W-1:0] tm);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 8);
            sample_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_if.valid <= 1'b1;
        sample_if.move_distance <= move_dist;
        sample_if.elapsed_time <= tm;
        @(posedge clk);
        while (!sample_if.ready)
            @(posedge clk);
        expected_points.push_back(eval_profile(move_dist, tm));
        moves_sent++;
    endtask

    task automatic drain_results();
        sample_if.valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    task automatic write_limit(logic [tpe_pkg::CFG_INDEX_W-1:0] idx, logic [W-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == tpe_pkg::REG_VELOCITY)
            vel_lim = val;
        else
            acc_lim = val;
    endtask

    function automatic logic [W-1:0] rand_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return W'($urandom_range(0, 3)) << $urandom_range(0, W - 2);
            3: return W'($urandom_range(1, 1 << 20));
            default: return W'($urandom());
        endcase
    endfunction

    // times spread over the whole move: around the ramp and the end
    function automatic logic [W-1:0] rand_time();
        case ($urandom_range(0, 3))
            0: return W'($urandom_range(0, 1 << 18));
            1: return W'($urandom_range(0, 1 << 22));
            2: return W'($urandom());
            default: return rand_value();
        endcase
    endfunction

    // receiver stalls and result checking
    initial
    begin
        profile_point_t got;
        profile_point_t want;
        result_if.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_if.valid && result_if.ready)
            begin
                got.position = result_if.position;
                got.speed = result_if.speed;
                got.phase = tpe_pkg::phase_t'(result_if.phase);
                if (expected_points.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat pos=%h", got.position);
                end
                else
                begin
                    want = expected_points.pop_front();
                    points_checked++;
                    if (int'(want.phase) < 5)
                        phase_seen[int'(want.phase)]++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp pos=%h spd=%h ph=%0d got pos=%h spd=%h ph=%0d",
                                want.position, want.speed, want.phase,
                                got.position, got.speed, got.phase);
                    end
                end
            end
            if (idle_on && $urandom_range(0, 5) == 0)
            begin
                result_if.ready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                result_if.ready <= 1'b1;
            end
            else
                result_if.ready <= 1'b1;
        end
    end

    task automatic test_reset_limits();
        send_move(32'sh0001_0000, 32'h0000_8000);
        send_move(32'sh0004_0000, 32'h0002_0000);
        send_move(32'shFFFC_0000, 32'h0003_0000);
        drain_results();
    endtask

    task automatic test_edges();
        write_limit(tpe_pkg::REG_VELOCITY, 32'h0002_0000);
        write_limit(tpe_pkg::REG_ACCEL, 32'h0001_0000);
        send_move(32'sh0000_0000, 32'h0);
        send_move(32'sh0000_0000, 32'h1);
        send_move(32'sh7FFF_FFFF, 32'h0);
        send_move(32'sh8000_0000, 32'hFFFF_FFFF);
        send_move(32'sh8000_0000, 32'h0100_0000);
        send_move(32'sh0010_0000, 32'h0002_0000);
        send_move(32'sh0010_0000, 32'h0005_0000);
        send_move(32'shFFF0_0000, 32'h0008_0000);
        send_move(32'sh0010_0000, 32'h0009_0000);
        send_move(32'sh0010_0000, 32'h000A_0000);
        send_move(32'sh0001_0000, 32'h0001_0000);
        drain_results();
        write_limit(tpe_pkg::REG_VELOCITY, '1);
        write_limit(tpe_pkg::REG_ACCEL, '1);
        send_move(32'sh7FFF_FFFF, 32'hFFFF_FFFF);
        send_move(32'sh0000_0001, 32'h0000_0001);
        drain_results();
        write_limit(tpe_pkg::REG_VELOCITY, 32'h0000_0001);
        write_limit(tpe_pkg::REG_ACCEL, 32'h0000_0001);
        send_move(32'sh7FFF_FFFF, 32'h8000_0000);
        send_move(32'sh0001_0000, 32'hFFFF_FFFF);
        drain_results();
    endtask

    task automatic test_zero_limits();
        write_limit(tpe_pkg::REG_VELOCITY, '0);
        send_move(32'sh0001_0000, 32'h0000_1000);
        drain_results();
        write_limit(tpe_pkg::REG_VELOCITY, 32'h0001_0000);
        write_limit(tpe_pkg::REG_ACCEL, '0);
        send_move(32'shFFFF_0000, 32'h0000_1000);
        drain_results();
    endtask

    task automatic test_random(int n_phases, int per_phase);
        for (int p = 0; p < n_phases; p++)
        begin
            write_limit(tpe_pkg::REG_VELOCITY, ($urandom_range(0, 9) == 0) ? rand_value()
                                       : W'($urandom_range(1 << 12, 1 << 20)));
            write_limit(tpe_pkg::REG_ACCEL, ($urandom_range(0, 9) == 0) ? rand_value()
                                    : W'($urandom_range(1 << 12, 1 << 20)));
            for (int i = 0; i < per_phase; i++)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_move(rand_value(), rand_time());
                else
                    send_move(W'($signed($urandom_range(0, 1 << 24)) *
                                 ($urandom_range(0, 1) ? 1 : -1)), rand_time());
            end
            drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_if.valid = 1'b0;
        sample_if.move_distance = '0;
        sample_if.elapsed_time = '0;
        vel_lim = 32'h0001_0000;
        acc_lim = 32'h0001_0000;
        mismatches = 0;
        points_checked = 0;
        moves_sent = 0;
        idle_on = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_limits();
        test_edges();
        test_zero_limits();
        test_random(8, 50);
        // last part streams with no idling at all
        idle_on = 1'b0;
        test_random(2, 50);

        $display("moves %0d checked %0d mismatches %0d", moves_sent, points_checked, mismatches);
        $display("phases accel %0d cruise %0d decel %0d done %0d error %0d",
            phase_seen[0], phase_seen[1], phase_seen[2], phase_seen[3], phase_seen[4]);
        if (mismatches == 0 && expected_points.size() == 0)
            $display("PASS trapezoid_profile_eval_unit");
        else
            $display("FAIL trapezoid_profile_eval_unit");
        $finish;
    end
endmodule

/* trapezoid_profile_eval_unit.f */
rtl/tpe_pkg.sv
rtl/tpe_if.sv
rtl/tpe_div_pipe.sv
rtl/tpe_sqrt_pipe.sv
rtl/tpe_eval_pipe.sv
rtl/trapezoid_profile_eval_unit.sv
rtl/tpe_checker.sv
tb/sv/tb_top.sv
